// ----- hdl/lrups_pkg.sv -----
// shared types and constants for the lru page replacement stack
// no dependencies; used by lrups_ctrl, lrups_dpath and the top level

package lrups_pkg;

   // default build sizes
   localparam int DEPTH_DEF     = 8;
   localparam int PAGE_BITS_DEF = 16;

   // capacity register and occupancy field are fixed at four bits
   localparam int          CAP_BITS  = 4;
   localparam logic [3:0]  CAP_RESET = 4'd8;
   localparam int          OCC_BITS  = 4;

   // per-item sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_UPDATE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_page;
      logic capture_match;
      logic update;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ----- hdl/lrups_ctrl.sv -----
// sequencer for the lru page replacement stack: accept, match, update
// depends on lrups_pkg for the state, command and status types

module lrups_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  lrups_pkg::status_type status,
   output lrups_pkg::cmd_type    cmd
);

   lrups_pkg::state_type state_ff;
   lrups_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrups_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lrups_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = lrups_pkg::ST_MATCH;
         end
         lrups_pkg::ST_MATCH: begin
            state_in = lrups_pkg::ST_UPDATE;
         end
         lrups_pkg::ST_UPDATE: begin
            if (status.out_free) state_in = lrups_pkg::ST_IDLE;
         end
         default: begin
            state_in = lrups_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      req_tready        = 1'b0;
      cmd.load_page     = 1'b0;
      cmd.capture_match = 1'b0;
      cmd.update        = 1'b0;
      case (state_ff)
         lrups_pkg::ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_page = req_tvalid;
         end
         lrups_pkg::ST_MATCH: begin
            cmd.capture_match = 1'b1;
         end
         lrups_pkg::ST_UPDATE: begin
            cmd.update = status.out_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ----- hdl/lrups_dpath.sv -----
// datapath of the lru page replacement stack: recency stack cells, fill count,
// capacity register, match vector and result register; depends on lrups_pkg

module lrups_dpath #(
   parameter int DEPTH     = lrups_pkg::DEPTH_DEF,
   parameter int PAGE_BITS = lrups_pkg::PAGE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lrups_pkg::cmd_type            cmd,
   output lrups_pkg::status_type         status,
   input  logic [PAGE_BITS-1:0]          page,
   input  logic                          csr_write,
   input  logic [lrups_pkg::CAP_BITS-1:0] csr_value,
   input  logic                          rsp_take,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic                          rsp_evict_valid,
   output logic [PAGE_BITS-1:0]          rsp_evicted_page,
   output logic [lrups_pkg::OCC_BITS-1:0] rsp_occupancy
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [PAGE_BITS-1:0]           page_ff;
   logic [PAGE_BITS-1:0]           stack_ff [DEPTH];
   logic [PAGE_BITS-1:0]           stack_in [DEPTH];
   logic [CNT_W-1:0]               fill_ff;
   logic [CNT_W-1:0]               fill_in;
   logic [lrups_pkg::CAP_BITS-1:0] cap_ff;
   logic [DEPTH-1:0]               match_ff;
   logic [DEPTH-1:0]               match_in;
   logic [DEPTH-1:0]               shift_sel;
   logic [CNT_W-1:0]               lim;
   logic                           hit;
   logic                           evict;
   logic [PAGE_BITS-1:0]           victim;

   logic                           rsp_valid_ff;
   logic                           rsp_hit_ff;
   logic                           rsp_evict_ff;
   logic [PAGE_BITS-1:0]           rsp_page_ff;
   logic [lrups_pkg::OCC_BITS-1:0] rsp_occ_ff;

   // frames in use: zero reads as one, above the built depth saturates
   always_comb begin
      if (cap_ff == '0) begin
         lim = CNT_W'(1);
      end else if (32'(cap_ff) > 32'(DEPTH)) begin
         lim = CNT_W'(DEPTH);
      end else begin
         lim = CNT_W'(cap_ff);
      end
   end

   // parallel compare against resident entries
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match_in[i] = (stack_ff[i] == page_ff) && (CNT_W'(i) < fill_ff);
      end
   end

   assign hit    = |match_ff;
   assign evict  = !hit && (fill_ff >= lim);
   assign victim = evict ? stack_ff[0] : '0;

   // entries at or above the first match close the gap; all shift on eviction
   always_comb begin
      logic acc;
      acc = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         acc          = acc | match_ff[i];
         shift_sel[i] = hit ? acc : evict;
      end
   end

   always_comb begin
      logic [CNT_W-1:0] wr_idx;
      logic             wr_en;
      if (hit || evict) begin
         fill_in = fill_ff;
         wr_idx  = fill_ff - CNT_W'(1);
         wr_en   = 1'b1;
      end else if (32'(fill_ff) < 32'(DEPTH)) begin
         fill_in = fill_ff + CNT_W'(1);
         wr_idx  = fill_ff;
         wr_en   = 1'b1;
      end else begin
         fill_in = fill_ff;
         wr_idx  = fill_ff;
         wr_en   = 1'b0;
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (shift_sel[i] && (CNT_W'(i + 1) < fill_ff)) begin
            stack_in[i] = stack_ff[(i + 1 < DEPTH) ? i + 1 : i];
         end else begin
            stack_in[i] = stack_ff[i];
         end
         if (wr_en && (wr_idx == CNT_W'(i))) begin
            stack_in[i] = page_ff;
         end
      end
   end

   // stack cells hold payload only
   always_ff @(posedge clock) begin
      if (cmd.load_page) page_ff <= page;
      if (cmd.capture_match) match_ff <= match_in;
      if (cmd.update) begin
         for (int i = 0; i < DEPTH; i++) begin
            stack_ff[i] <= stack_in[i];
         end
         rsp_hit_ff   <= hit;
         rsp_evict_ff <= evict;
         rsp_page_ff  <= victim;
         rsp_occ_ff   <= lrups_pkg::OCC_BITS'(fill_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         cap_ff       <= lrups_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.update) fill_ff <= fill_in;
         if (csr_write) cap_ff <= csr_value;
         if (cmd.update) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.out_free  = !rsp_valid_ff || rsp_take;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_evict_valid  = rsp_evict_ff;
   assign rsp_evicted_page = rsp_page_ff;
   assign rsp_occupancy    = rsp_occ_ff;

endmodule

// ----- hdl/lru_page_replacement_stack.sv -----
// top level of the lru page replacement stack
// depends on lrups_pkg, lrups_ctrl and lrups_dpath

// usage
// - req channel: one page reference per item; req_tdata carries the page
// - rsp channel: one result per reference, carrying hit, evict flag, the
//   evicted page (zero when none) and the occupancy after the reference
// - csr channel: writes the capacity register (frames in use); csr_ready is
//   always high, write only while no reference is in flight
// - sequence: a reference is taken in the idle state, compared against all
//   resident entries in the match state, and the stack is updated and the
//   result registered in the update state; rsp_tvalid comes from that register
// - one reference at a time: the three-step sequencer (accept, parallel
//   compare, shift and write) takes a new one only after the update step
// - the next reference is accepted while a result still waits on rsp
// - receiver stall: a held result keeps its value; a following reference
//   waits in the update step until the result register frees up
// - reset: the stack empties (fill count zero), capacity returns to 8 and
//   no result is pending; stack cells are not cleared
// - capacity zero acts as one, above the depth acts as the depth; lowering
//   it flushes nothing and the fill count stays: each miss evicts one page

module lru_page_replacement_stack #(
   parameter int DEPTH     = lrups_pkg::DEPTH_DEF,
   parameter int PAGE_BITS = lrups_pkg::PAGE_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   // page references
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [PAGE_BITS-1:0] page, zero padded
   input  logic [((PAGE_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // results
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] hit, [1] evict_valid, [PAGE_BITS+1:2] evicted_page,
   // [PAGE_BITS+5:PAGE_BITS+2] occupancy, zero padded
   output logic [((PAGE_BITS + 13) / 8) * 8 - 1:0] rsp_tdata,
   // capacity register write
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lrups_pkg::CAP_BITS-1:0]       csr_data
);

   localparam int RSP_W = ((PAGE_BITS + 13) / 8) * 8;
   localparam int RSP_USED = PAGE_BITS + 2 + lrups_pkg::OCC_BITS;

   lrups_pkg::cmd_type    cmd;
   lrups_pkg::status_type status;

   logic                           rsp_hit;
   logic                           rsp_evict_valid;
   logic [PAGE_BITS-1:0]           rsp_evicted_page;
   logic [lrups_pkg::OCC_BITS-1:0] rsp_occupancy;

   // configuration is always taken
   assign csr_ready = 1'b1;

   lrups_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lrups_dpath #(
      .DEPTH     (DEPTH),
      .PAGE_BITS (PAGE_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .page             (req_tdata[PAGE_BITS-1:0]),
      .csr_write        (csr_valid & csr_ready),
      .csr_value        (csr_data),
      .rsp_take         (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_hit          (rsp_hit),
      .rsp_evict_valid  (rsp_evict_valid),
      .rsp_evicted_page (rsp_evicted_page),
      .rsp_occupancy    (rsp_occupancy)
   );

   // pack result fields, lowest first
   assign rsp_tdata = RSP_W'({rsp_occupancy, rsp_evicted_page, rsp_evict_valid, rsp_hit})
                      & {{(RSP_W - RSP_USED){1'b0}}, {RSP_USED{1'b1}}};

endmodule
